// ----- sv/duration_text_parser_core_macros.svh -----
// assertion macros for the duration text parser core
// no dependencies; included by the core, which checks its own logic
`ifndef DURATION_TEXT_PARSER_CORE_MACROS_SVH
`define DURATION_TEXT_PARSER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define DTP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define DTP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/dtp_pkg.sv -----
// shared types, constants and unit tables for the duration text parser
// no dependencies; used by the channel interfaces and the core
package dtp_pkg;

   // longest unit word kept, in characters
   localparam int MAX_UNIT_LEN = 7;
   localparam int UNIT_TXT_W   = 8 * MAX_UNIT_LEN;
   localparam int ULEN_W       = $clog2(MAX_UNIT_LEN + 2);

   localparam int VALUE_W = 63;
   localparam int SECS_W  = 25;
   localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

   // seconds per unit
   localparam logic [SECS_W-1:0] SECS_SEC   = SECS_W'(1);
   localparam logic [SECS_W-1:0] SECS_MIN   = SECS_W'(60);
   localparam logic [SECS_W-1:0] SECS_HOUR  = SECS_W'(60 * 60);
   localparam logic [SECS_W-1:0] SECS_DAY   = SECS_W'(24 * 60 * 60);
   localparam logic [SECS_W-1:0] SECS_WEEK  = SECS_W'(7 * 24 * 60 * 60);
   localparam logic [SECS_W-1:0] SECS_MONTH = SECS_W'(30 * 24 * 60 * 60);
   localparam logic [SECS_W-1:0] SECS_YEAR  = SECS_W'(365 * 24 * 60 * 60);

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_DIGIT        = 3'd1,
      ST_TOO_LARGE    = 3'd2,
      ST_UNKNOWN_UNIT = 3'd3,
      ST_TRAILING     = 3'd4,
      ST_OVERFLOW     = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      PH_BEFORE,
      PH_NUMBER,
      PH_AFTER,
      PH_UNIT,
      PH_ERROR
   } phase_type;

   typedef enum logic [2:0] {
      UNIT_NONE,
      UNIT_SEC,
      UNIT_MIN,
      UNIT_HOUR,
      UNIT_DAY,
      UNIT_WEEK,
      UNIT_MONTH,
      UNIT_YEAR
   } unit_type;

   // unit word lookup; text is right aligned, first letter highest, zero filled
   function automatic unit_type unit_decode(input logic [UNIT_TXT_W-1:0] txt);
      unit_type u;
      case (txt)
         UNIT_TXT_W'("s"), UNIT_TXT_W'("sec"), UNIT_TXT_W'("second"),
         UNIT_TXT_W'("seconds"):                         u = UNIT_SEC;
         UNIT_TXT_W'("m"), UNIT_TXT_W'("min"), UNIT_TXT_W'("minute"),
         UNIT_TXT_W'("minutes"):                         u = UNIT_MIN;
         UNIT_TXT_W'("h"), UNIT_TXT_W'("hr"), UNIT_TXT_W'("hour"),
         UNIT_TXT_W'("hours"):                           u = UNIT_HOUR;
         UNIT_TXT_W'("d"), UNIT_TXT_W'("day"), UNIT_TXT_W'("days"):
                                                         u = UNIT_DAY;
         UNIT_TXT_W'("w"), UNIT_TXT_W'("wk"), UNIT_TXT_W'("week"),
         UNIT_TXT_W'("weeks"):                           u = UNIT_WEEK;
         UNIT_TXT_W'("mo"), UNIT_TXT_W'("month"), UNIT_TXT_W'("months"):
                                                         u = UNIT_MONTH;
         UNIT_TXT_W'("y"), UNIT_TXT_W'("yr"), UNIT_TXT_W'("year"),
         UNIT_TXT_W'("years"):                           u = UNIT_YEAR;
         default:                                        u = UNIT_NONE;
      endcase
      return u;
   endfunction

   function automatic logic [SECS_W-1:0] unit_secs(input unit_type u);
      logic [SECS_W-1:0] s;
      case (u)
         UNIT_SEC:   s = SECS_SEC;
         UNIT_MIN:   s = SECS_MIN;
         UNIT_HOUR:  s = SECS_HOUR;
         UNIT_DAY:   s = SECS_DAY;
         UNIT_WEEK:  s = SECS_WEEK;
         UNIT_MONTH: s = SECS_MONTH;
         UNIT_YEAR:  s = SECS_YEAR;
         default:    s = '0;
      endcase
      return s;
   endfunction

endpackage

// ----- sv/dtp_ifs.sv -----
// valid/ready channel interfaces for the duration text parser
// depends on dtp_pkg for the status type

// text bytes in
interface dtp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       char_valid;
   logic       last_item;

   modport source (output valid, output char_code, output char_valid,
                   output last_item, input ready);
   modport sink   (input valid, input char_code, input char_valid,
                   input last_item, output ready);
endinterface

// totals out
interface dtp_rsp_if;
   logic                  valid;
   logic                  ready;
   logic [62:0]           total_seconds;
   dtp_pkg::status_type   status;

   modport source (output valid, output total_seconds, output status, input ready);
   modport sink   (input valid, input total_seconds, input status, output ready);
endinterface

// ----- sv/duration_text_parser_core.sv -----
// duration text parser core: byte-wide parser front end and term pipeline
// depends on dtp_pkg, dtp_ifs.sv and duration_text_parser_core_macros.svh
//
// Usage
//   req_chan carries one byte of a duration text per item (char_code, with
//   char_valid = 0 for an empty text) and last_item on the final item. The
//   text is parsed as number/unit terms such as "1h 30m", summed in seconds.
//   rsp_chan carries one item per text: total_seconds and status. The total
//   is zero whenever status is not ok.
//   Throughput: one byte per cycle while req_chan.ready is high, with no gap
//   needed between texts. Path: after the edge that accepted the last item
//   of its text, a result passes the scaling multiply, split at bit 32 into
//   a low and a high partial product, the product merge, the term sum and
//   the accumulate into the running total, then lands in the output register.
//   Stall: the result waits in an output register; bytes keep flowing while
//   it waits, and req_chan.ready drops only when a second result reaches the
//   end of the pipeline while the first one is still held.
//   Reset: synchronous, active high; clears the parser state, the pipeline
//   valid flags, the running total and the output valid flag. No result is
//   produced for a text cut short by reset.

`include "duration_text_parser_core_macros.svh"

module duration_text_parser_core (
   input logic      clock,
   input logic      reset,
   dtp_req_if.sink  req_chan,
   dtp_rsp_if.source rsp_chan
);
   import dtp_pkg::*;

   // handshake and pipeline advance
   logic adv;
   logic accept;
   logic take;
   logic fin;

   // character classes
   logic [7:0] c;
   logic       c_space;
   logic       c_digit;
   logic       c_letter;

   // parser state
   phase_type             phase_ff, phase_in;
   logic [VALUE_W-1:0]    num_ff, num_in;
   logic [UNIT_TXT_W-1:0] unit_ff, unit_in;
   logic [ULEN_W-1:0]     ulen_ff, ulen_in;
   status_type            err_ff, err_in;

   // term events from the parser
   logic               sc_tv;
   logic [VALUE_W-1:0] sc_tnum;
   unit_type           sc_tunit;
   logic               sc_pv;
   logic [VALUE_W-1:0] sc_pnum;

   // stage 1: terms captured
   logic               p1_last_ff, p1_last_in;
   status_type         p1_err_ff, p1_err_in;
   logic               p1_tv_ff, p1_tv_in;
   logic               p1_pv_ff, p1_pv_in;
   logic [VALUE_W-1:0] p1_num_ff, p1_num_in;
   unit_type           p1_unit_ff, p1_unit_in;
   logic [VALUE_W-1:0] p1_plain_ff, p1_plain_in;

   // stage 2: low partial product
   logic               p2_last_ff;
   status_type         p2_err_ff;
   logic               p2_tv_ff;
   logic               p2_pv_ff;
   logic [56:0]        p2_lo_ff, p2_lo_in;
   logic [30:0]        p2_nhi_ff;
   logic [SECS_W-1:0]  p2_secs_ff, p2_secs_in;
   logic [VALUE_W-1:0] p2_plain_ff;

   // stage 3: high partial product
   logic               p3_last_ff;
   status_type         p3_err_ff;
   logic               p3_tv_ff;
   logic               p3_pv_ff;
   logic [55:0]        p3_hi_ff, p3_hi_in;
   logic [56:0]        p3_lo_ff;
   logic [VALUE_W-1:0] p3_plain_ff;

   // stage 4: merged product
   logic               p4_last_ff;
   status_type         p4_err_ff;
   logic               p4_tv_ff;
   logic               p4_pv_ff;
   logic [87:0]        prod_w;
   logic [VALUE_W-1:0] p4_prod_ff;
   logic               p4_big_ff, p4_big_in;
   logic [VALUE_W-1:0] p4_plain_ff;

   // stage 5: item sum
   logic               p5_last_ff;
   status_type         p5_err_ff;
   logic               p5_term_ff, p5_term_in;
   logic [VALUE_W:0]   add_w;
   logic [VALUE_W-1:0] p5_add_ff;
   logic               p5_ovf_ff, p5_ovf_in;

   // accumulator and output register
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic               acc_ovf_ff, acc_ovf_in;
   logic [VALUE_W:0]   sum_w;
   logic               ovf_w;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_total_ff, rsp_total_in;
   status_type         rsp_status_ff, rsp_status_in;

   // a held result blocks only when another result is about to land on it
   assign adv    = !(rsp_valid_ff && !rsp_chan.ready && p5_last_ff);
   assign accept = req_chan.valid && adv;
   assign take   = accept && req_chan.char_valid;
   assign fin    = accept && req_chan.last_item;
   assign req_chan.ready = adv;

   assign c        = req_chan.char_code;
   assign c_space  = (c == 8'h20) || (c inside {[8'h09:8'h0D]});
   assign c_digit  = c inside {[8'h30:8'h39]};
   assign c_letter = (c inside {[8'h41:8'h5A]}) || (c inside {[8'h61:8'h7A]});

   // parser next state: byte step, then end-of-text close
   always_comb begin
      phase_type             ph;
      logic [VALUE_W-1:0]    n;
      logic [UNIT_TXT_W-1:0] u;
      logic [ULEN_W-1:0]     l;
      status_type            e;
      logic                  do_before;
      logic [VALUE_W+3:0]    n10;
      unit_type              uc;

      ph        = phase_ff;
      n         = num_ff;
      u         = unit_ff;
      l         = ulen_ff;
      e         = err_ff;
      do_before = 1'b0;
      n10       = '0;
      uc        = UNIT_NONE;
      sc_tv     = 1'b0;
      sc_tnum   = num_ff;
      sc_tunit  = UNIT_NONE;
      sc_pv     = 1'b0;
      sc_pnum   = num_ff;

      if (take) begin
         case (ph)
            PH_BEFORE: begin
               do_before = 1'b1;
            end
            PH_NUMBER: begin
               if (c_digit) begin
                  n10 = ({4'b0, n} << 3) + ({4'b0, n} << 1) + (VALUE_W + 4)'(c[3:0]);
                  if (n10[VALUE_W+3:VALUE_W] != '0) begin
                     if (e == ST_OK) e = ST_TOO_LARGE;
                     ph = PH_ERROR;
                  end else begin
                     n = n10[VALUE_W-1:0];
                  end
               end else if (c_space) begin
                  ph = PH_AFTER;
               end else if (c_letter) begin
                  u  = UNIT_TXT_W'(c);
                  l  = ULEN_W'(1);
                  ph = PH_UNIT;
               end else begin
                  if (e == ST_OK) e = ST_TRAILING;
                  ph = PH_ERROR;
               end
            end
            PH_AFTER: begin
               if (c_letter) begin
                  u  = UNIT_TXT_W'(c);
                  l  = ULEN_W'(1);
                  ph = PH_UNIT;
               end else if (!c_space) begin
                  if (e == ST_OK) e = ST_TRAILING;
                  ph = PH_ERROR;
               end
            end
            PH_UNIT: begin
               if (c_letter) begin
                  if (l < ULEN_W'(MAX_UNIT_LEN)) begin
                     u = {u[UNIT_TXT_W-9:0], c};
                     l = l + ULEN_W'(1);
                  end else begin
                     l = ULEN_W'(MAX_UNIT_LEN + 1);
                  end
               end else begin
                  // unit word ends on this byte
                  uc = unit_decode(u);
                  if (l <= ULEN_W'(MAX_UNIT_LEN) && uc != UNIT_NONE) begin
                     sc_tv     = 1'b1;
                     sc_tnum   = n;
                     sc_tunit  = uc;
                     n         = '0;
                     l         = '0;
                     ph        = PH_BEFORE;
                     do_before = 1'b1;
                  end else begin
                     if (e == ST_OK) e = ST_UNKNOWN_UNIT;
                     ph = PH_ERROR;
                  end
               end
            end
            default: begin
            end
         endcase

         // start of a number, whitespace allowed
         if (do_before) begin
            if (c_digit) begin
               n  = VALUE_W'(c[3:0]);
               ph = PH_NUMBER;
            end else if (!c_space) begin
               if (e == ST_OK) e = ST_DIGIT;
               ph = PH_ERROR;
            end
         end
      end

      // end of text: close the open term
      if (fin) begin
         if (ph == PH_NUMBER || ph == PH_AFTER) begin
            sc_pv   = 1'b1;
            sc_pnum = n;
         end else if (ph == PH_UNIT) begin
            uc = unit_decode(u);
            if (l <= ULEN_W'(MAX_UNIT_LEN) && uc != UNIT_NONE) begin
               sc_tv    = 1'b1;
               sc_tnum  = n;
               sc_tunit = uc;
            end else if (e == ST_OK) begin
               e = ST_UNKNOWN_UNIT;
            end
         end
      end

      p1_err_in = e;
      if (fin) begin
         phase_in = PH_BEFORE;
         num_in   = '0;
         unit_in  = '0;
         ulen_in  = '0;
         err_in   = ST_OK;
      end else begin
         phase_in = ph;
         num_in   = n;
         unit_in  = u;
         ulen_in  = l;
         err_in   = e;
      end
   end

   // parser outputs into stage 1
   always_comb begin
      p1_last_in  = fin;
      p1_tv_in    = accept && sc_tv;
      p1_pv_in    = accept && sc_pv;
      p1_num_in   = sc_tnum;
      p1_unit_in  = sc_tunit;
      p1_plain_in = sc_pnum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_BEFORE;
         num_ff   <= '0;
         unit_ff  <= '0;
         ulen_ff  <= '0;
         err_ff   <= ST_OK;
      end else if (accept) begin
         phase_ff <= phase_in;
         num_ff   <= num_in;
         unit_ff  <= unit_in;
         ulen_ff  <= ulen_in;
         err_ff   <= err_in;
      end
   end

   // partial products and term sum
   assign p2_secs_in = unit_secs(p1_unit_ff);
   assign p2_lo_in   = 57'(p1_num_ff[31:0]) * 57'(p2_secs_in);
   assign p3_hi_in   = 56'(p2_nhi_ff) * 56'(p2_secs_ff);
   assign prod_w     = {p3_hi_ff, 32'b0} + 88'(p3_lo_ff);
   assign p4_big_in  = prod_w[87:VALUE_W] != '0;
   assign add_w      = (p4_tv_ff ? {1'b0, p4_prod_ff} : '0)
                     + (p4_pv_ff ? {1'b0, p4_plain_ff} : '0);
   assign p5_term_in = p4_tv_ff || p4_pv_ff;
   assign p5_ovf_in  = (p4_tv_ff && p4_big_ff) || add_w[VALUE_W];

   // pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_last_ff <= 1'b0;
         p1_tv_ff   <= 1'b0;
         p1_pv_ff   <= 1'b0;
         p1_err_ff  <= ST_OK;
         p2_last_ff <= 1'b0;
         p2_tv_ff   <= 1'b0;
         p2_pv_ff   <= 1'b0;
         p2_err_ff  <= ST_OK;
         p3_last_ff <= 1'b0;
         p3_tv_ff   <= 1'b0;
         p3_pv_ff   <= 1'b0;
         p3_err_ff  <= ST_OK;
         p4_last_ff <= 1'b0;
         p4_tv_ff   <= 1'b0;
         p4_pv_ff   <= 1'b0;
         p4_err_ff  <= ST_OK;
         p5_last_ff <= 1'b0;
         p5_term_ff <= 1'b0;
         p5_ovf_ff  <= 1'b0;
         p5_err_ff  <= ST_OK;
      end else if (adv) begin
         p1_last_ff <= p1_last_in;
         p1_tv_ff   <= p1_tv_in;
         p1_pv_ff   <= p1_pv_in;
         p1_err_ff  <= p1_err_in;
         p2_last_ff <= p1_last_ff;
         p2_tv_ff   <= p1_tv_ff;
         p2_pv_ff   <= p1_pv_ff;
         p2_err_ff  <= p1_err_ff;
         p3_last_ff <= p2_last_ff;
         p3_tv_ff   <= p2_tv_ff;
         p3_pv_ff   <= p2_pv_ff;
         p3_err_ff  <= p2_err_ff;
         p4_last_ff <= p3_last_ff;
         p4_tv_ff   <= p3_tv_ff;
         p4_pv_ff   <= p3_pv_ff;
         p4_err_ff  <= p3_err_ff;
         p5_last_ff <= p4_last_ff;
         p5_term_ff <= p5_term_in;
         p5_ovf_ff  <= p5_ovf_in;
         p5_err_ff  <= p4_err_ff;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (adv) begin
         p1_num_ff   <= p1_num_in;
         p1_unit_ff  <= p1_unit_in;
         p1_plain_ff <= p1_plain_in;
         p2_lo_ff    <= p2_lo_in;
         p2_nhi_ff   <= p1_num_ff[VALUE_W-1:32];
         p2_secs_ff  <= p2_secs_in;
         p2_plain_ff <= p1_plain_ff;
         p3_hi_ff    <= p3_hi_in;
         p3_lo_ff    <= p2_lo_ff;
         p3_plain_ff <= p2_plain_ff;
         p4_prod_ff  <= prod_w[VALUE_W-1:0];
         p4_big_ff   <= p4_big_in;
         p4_plain_ff <= p3_plain_ff;
         p5_add_ff   <= add_w[VALUE_W-1:0];
      end
   end

   // running total; any overflow outranks a later parse error
   assign sum_w = {1'b0, acc_ff} + (p5_term_ff ? {1'b0, p5_add_ff} : '0);
   assign ovf_w = acc_ovf_ff || (p5_term_ff && (p5_ovf_ff || sum_w[VALUE_W]));

   always_comb begin
      if (p5_last_ff) begin
         acc_in     = '0;
         acc_ovf_in = 1'b0;
      end else begin
         acc_in     = sum_w[VALUE_W-1:0];
         acc_ovf_in = ovf_w;
      end
      rsp_total_in  = (ovf_w || p5_err_ff != ST_OK) ? '0 : sum_w[VALUE_W-1:0];
      rsp_status_in = ovf_w ? ST_OVERFLOW : p5_err_ff;
      if (adv && p5_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         acc_ovf_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            acc_ff     <= acc_in;
            acc_ovf_ff <= acc_ovf_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && p5_last_ff) begin
         rsp_total_ff  <= rsp_total_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.total_seconds = rsp_total_ff;
   assign rsp_chan.status        = rsp_status_ff;

   // checks on the parser and pipeline
   `DTP_ASSERT_NOW(a_err_total_zero, clock, reset,
      rsp_valid_ff && rsp_status_ff != ST_OK, rsp_total_ff == '0,
      "failed result carries a non-zero total")
   `DTP_ASSERT_NEXT(a_text_restart, clock, reset,
      fin, phase_ff == PH_BEFORE && num_ff == '0 && err_ff == ST_OK,
      "parser state not cleared after the last item")
   `DTP_ASSERT_NOW(a_ready_only_blocked, clock, reset,
      !req_chan.ready, rsp_valid_ff && p5_last_ff,
      "input held off without a result waiting on the output")
   `DTP_ASSERT_NEXT(a_ovf_sticky, clock, reset,
      acc_ovf_ff && !(adv && p5_last_ff), acc_ovf_ff,
      "overflow flag lost before the text ended")
   `DTP_ASSERT_NOW(a_error_phase_code, clock, reset,
      phase_ff == PH_ERROR, err_ff != ST_OK,
      "parser in error phase without an error code")

endmodule

// ----- dv/tb.sv -----
// self-checking testbench for duration_text_parser_core: byte texts in, totals out
// depends on dtp_pkg and the channel interfaces in dtp_ifs.sv; the class below
// predicts each total and status and checks them against the block's results
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dtp_pkg::*;

   localparam int PERIOD       = 10;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 430;
   localparam int WORD_W       = 8 * MAX_UNIT_LEN;
   localparam longint unsigned TOTAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef logic [7:0] text_t[$];

   typedef struct {
      logic [62:0] total;
      status_type  status;
   } total_rec;

   // running parse of the text and the queue of totals still to come
   class total_checker;
      phase_type              phase;
      longint unsigned        number;
      longint unsigned        total;
      logic [WORD_W-1:0]      word_bits;
      int                     word_len;
      status_type             fault;
      total_rec               pending_totals[$];
      int                     failures;

      function new();
         failures = 0;
         clear();
      endfunction

      function void clear();
         phase     = PH_BEFORE;
         number    = 0;
         total     = 0;
         word_bits = '0;
         word_len  = 0;
         fault     = ST_OK;
      endfunction

      function bit is_blank(logic [7:0] c);
         return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
      endfunction

      function bit is_num(logic [7:0] c);
         return c >= 8'h30 && c <= 8'h39;
      endfunction

      function bit is_alpha(logic [7:0] c);
         return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
      endfunction

      // seconds per unit word, zero for a word not known
      function longint unsigned word_seconds(logic [WORD_W-1:0] w);
         case (w)
            WORD_W'("s"), WORD_W'("sec"), WORD_W'("second"), WORD_W'("seconds"):
               return 1;
            WORD_W'("m"), WORD_W'("min"), WORD_W'("minute"), WORD_W'("minutes"):
               return 60;
            WORD_W'("h"), WORD_W'("hr"), WORD_W'("hour"), WORD_W'("hours"):
               return 3600;
            WORD_W'("d"), WORD_W'("day"), WORD_W'("days"):
               return 86400;
            WORD_W'("w"), WORD_W'("wk"), WORD_W'("week"), WORD_W'("weeks"):
               return 604800;
            WORD_W'("mo"), WORD_W'("month"), WORD_W'("months"):
               return 2592000;
            WORD_W'("y"), WORD_W'("yr"), WORD_W'("year"), WORD_W'("years"):
               return 31536000;
            default:
               return 0;
         endcase
      endfunction

      // first error wins, later bytes are ignored
      function void raise(status_type code);
         if (fault == ST_OK) fault = code;
         phase = PH_ERROR;
      endfunction

      function void add_letter(logic [7:0] c);
         if (word_len < MAX_UNIT_LEN) begin
            word_bits = {word_bits[WORD_W-9:0], c};
            word_len++;
         end else begin
            word_len = MAX_UNIT_LEN + 1;
         end
      endfunction

      function void start_word(logic [7:0] c);
         word_bits = '0;
         word_len  = 0;
         phase     = PH_UNIT;
         add_letter(c);
      endfunction

      // scale the number and accumulate, flagging overflow
      function void add_term(longint unsigned mult);
         longint unsigned prod;
         if (number > TOTAL_MAX / mult) begin
            raise(ST_OVERFLOW);
            return;
         end
         prod = number * mult;
         if (prod > TOTAL_MAX - total) begin
            raise(ST_OVERFLOW);
            return;
         end
         total     = total + prod;
         number    = 0;
         word_len  = 0;
         word_bits = '0;
         phase     = PH_BEFORE;
      endfunction

      function void close_word();
         longint unsigned secs;
         secs = (word_len <= MAX_UNIT_LEN) ? word_seconds(word_bits) : 0;
         if (secs != 0) add_term(secs);
         else raise(ST_UNKNOWN_UNIT);
      endfunction

      function void first_of_number(logic [7:0] c);
         if (is_blank(c)) return;
         if (is_num(c)) begin
            number = longint'(c - 8'h30);
            phase  = PH_NUMBER;
         end else begin
            raise(ST_DIGIT);
         end
      endfunction

      function void take_char(logic [7:0] c);
         longint unsigned d;
         d = longint'(c) - 48;
         case (phase)
            PH_BEFORE: first_of_number(c);
            PH_NUMBER: begin
               if (is_num(c)) begin
                  if (number > (TOTAL_MAX - d) / 10) raise(ST_TOO_LARGE);
                  else number = number * 10 + d;
               end else if (is_blank(c)) begin
                  phase = PH_AFTER;
               end else if (is_alpha(c)) begin
                  start_word(c);
               end else begin
                  raise(ST_TRAILING);
               end
            end
            PH_AFTER: begin
               if (is_alpha(c)) start_word(c);
               else if (!is_blank(c)) raise(ST_TRAILING);
            end
            PH_UNIT: begin
               if (is_alpha(c)) begin
                  add_letter(c);
               end else begin
                  close_word();
                  if (phase == PH_BEFORE) first_of_number(c);
               end
            end
            default: ;
         endcase
      endfunction

      // an accepted item: parse it, and on the last one queue the total
      function void note_item(logic [7:0] c, logic cv, logic last);
         total_rec rec;
         if (cv) take_char(c);
         if (!last) return;
         if (phase == PH_NUMBER || phase == PH_AFTER) add_term(1);
         else if (phase == PH_UNIT) close_word();
         rec.total  = (fault != ST_OK) ? 63'd0 : total[62:0];
         rec.status = fault;
         pending_totals.push_back(rec);
         clear();
      endfunction

      // a result from the block against the oldest expected total
      function void check_total(logic [62:0] t, status_type s);
         total_rec want;
         if (pending_totals.size() == 0) begin
            $display("%0t: unexpected result total %0d status %0d", $realtime, t, s);
            failures++;
            return;
         end
         want = pending_totals.pop_front();
         if (t !== want.total) begin
            $display("%0t: total_seconds expected %0d actual %0d",
                     $realtime, want.total, t);
            failures++;
         end
         if (s !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, want.status, s);
            failures++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   bit   idle_on  = 1'b1;
   bit   stall_on = 1'b1;
   int   cycle_count = 0;
   int   sent_items  = 0;
   int   texts_sent  = 0;

   total_checker board = new();

   string unit_words[26] = '{
      "s", "sec", "second", "seconds", "m", "min", "minute", "minutes",
      "h", "hr", "hour", "hours", "d", "day", "days", "w", "wk", "week", "weeks",
      "mo", "month", "months", "y", "yr", "year", "years"
   };

   dtp_req_if req_chan ();
   dtp_rsp_if rsp_chan ();

   duration_text_parser_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #(PERIOD / 2) clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // result side back-pressure
   initial begin
      rsp_chan.ready = 1'b1;
      forever begin
         @(negedge clock);
         rsp_chan.ready = (stall_on && $urandom_range(99) < 9) ? 1'b0 : 1'b1;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
         board.check_total(rsp_chan.total_seconds, rsp_chan.status);
   end

   // one item, held until accepted
   task automatic send_item(input logic [7:0] c, input logic cv, input logic last);
      @(negedge clock);
      while (idle_on && $urandom_range(99) < 9) begin
         req_chan.valid      = 1'b0;
         req_chan.char_code  = 8'($urandom);
         req_chan.char_valid = 1'($urandom);
         req_chan.last_item  = 1'($urandom);
         @(negedge clock);
      end
      req_chan.valid      = 1'b1;
      req_chan.char_code  = c;
      req_chan.char_valid = cv;
      req_chan.last_item  = last;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      board.note_item(c, cv, last);
   endtask

   // a whole text, with empty filler items now and then
   task automatic send_text(input text_t t);
      int  n;
      bit  tail;
      n    = t.size();
      tail = (n == 0) || ($urandom_range(9) == 0);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
         send_item(t[i], 1'b1, !tail && i == n - 1);
         sent_items++;
      end
      if (tail) begin
         send_item(8'($urandom), 1'b0, 1'b1);
         sent_items++;
      end
      texts_sent++;
   endtask

   function automatic text_t text_of(input string s);
      text_t t;
      for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
      return t;
   endfunction

   function automatic void add_word(ref text_t t, input string w);
      for (int i = 0; i < w.len(); i++) t.push_back(w[i]);
   endfunction

   function automatic logic [7:0] pick_blank();
      int r;
      r = $urandom_range(7);
      return (r > 4) ? 8'h20 : 8'(8'h09 + r);
   endfunction

   // mostly well-formed terms, some odd words, some damaged texts
   function automatic text_t make_text();
      text_t t;
      int    terms;
      int    kind;
      int    ndig;
      int    p;
      terms = $urandom_range(1, 3);
      kind  = $urandom_range(99);
      if (kind < 4) begin
         repeat ($urandom_range(3)) t.push_back(pick_blank());
         return t;
      end
      if ($urandom_range(7) == 0) t.push_back(pick_blank());
      for (int k = 0; k < terms; k++) begin
         ndig = ($urandom_range(19) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 4);
         repeat (ndig) t.push_back(8'(8'h30 + $urandom_range(9)));
         if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) t.push_back(pick_blank());
         if (k == terms - 1 && $urandom_range(4) == 0) begin
            // bare number closes the text
         end else if ($urandom_range(11) == 0) begin
            repeat ($urandom_range(1, 9))
               t.push_back(8'(($urandom_range(1) ? 8'h41 : 8'h61) + $urandom_range(25)));
         end else begin
            add_word(t, unit_words[$urandom_range(25)]);
         end
         if ($urandom_range(1) == 0) t.push_back(pick_blank());
      end
      // damage: replace or insert an arbitrary byte
      if (kind >= 85) begin
         p = $urandom_range(t.size() - 1);
         if ($urandom_range(1)) t[p] = 8'($urandom);
         else t.insert(p, 8'($urandom));
      end
      return t;
   endfunction

   initial begin
      text_t t;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.char_code  = 8'h00;
      req_chan.char_valid = 1'b0;
      req_chan.last_item  = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed texts: empty, blank, limits and each kind of error
      t = {};
      send_text(t);
      send_text(text_of(" \011\012\013\014\015"));
      send_text(text_of("1h 30m"));
      send_text(text_of("9223372036854775807"));
      send_text(text_of("9223372036854775808"));
      send_text(text_of("x5s"));
      send_text(text_of("5 q"));
      send_text(text_of("5secondss"));
      send_text(text_of("5Sec"));
      send_text(text_of("5 6"));
      t = text_of("5");
      t.push_back(8'h00);
      send_text(t);
      t = text_of("1s");
      t.push_front(8'hFF);
      send_text(t);
      t = text_of("1h");
      t.push_back(8'h80);
      send_text(t);
      send_text(text_of("9223372036854775807m"));
      send_text(text_of("9223372036854775807s 1s"));
      send_text(text_of("2mo 1y 3wk 4d 5hr 6min 7sec"));
      send_text(text_of("1seconds2minutes3hours4days5weeks6months7years"));
      send_text(text_of("1second 2minute 3hour 4day 5week 6month 7year 8 s9"));
      send_text(text_of("1w 1m 1h 1d 1y 1wk 1yr 3 m "));

      // hold off until the block has drained
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (board.pending_totals.size() != 0) @(posedge clock);

      // random texts, with a stretch free of idling on both sides
      sent_items = 0;
      texts_sent = 0;
      while (sent_items < RANDOM_ITEMS) begin
         idle_on  = !(texts_sent >= 8 && texts_sent < 20);
         stall_on = idle_on;
         send_text(make_text());
      end
      idle_on  = 1'b1;
      stall_on = 1'b1;

      @(negedge clock);
      req_chan.valid = 1'b0;
      while (board.pending_totals.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (board.failures == 0 && board.pending_totals.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

// ----- files.f -----
+incdir+sv
sv/dtp_pkg.sv
sv/dtp_ifs.sv
sv/duration_text_parser_core.sv
dv/tb.sv
